@@ rtl/dfs_pkg.sv @@
package dfs_pkg;

    localparam int CFG_W = 7;
    localparam logic [CFG_W-1:0] VCOUNT_RESET = 7'd64;

    typedef enum logic [1:0] {
        CMD_ADD_EDGE = 2'd0,
        CMD_RUN      = 2'd1,
        CMD_CLEAR    = 2'd2
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD_WAIT,
        ST_ROOT,
        ST_LOAD,
        ST_SCAN,
        ST_POP,
        ST_EMIT_RD,
        ST_EMIT_LOAD,
        ST_EMIT_HOLD
    } state_t;

    typedef struct packed {
        logic [1:0] command;
        logic [5:0] from_vertex;
        logic [5:0] to_vertex;
    } in_word_t;

    typedef struct packed {
        logic [5:0] vertex;
        logic [7:0] discover_time;
        logic [7:0] finish_time;
        logic       last;
    } out_word_t;

    typedef struct packed {
        logic clr_visited;
        logic mark_visited;
        logic ptr_load;
        logic ptr_step;
        logic load_row;
    } scan_ctrl_t;

    typedef struct packed {
        logic hit;
        logic at_end;
        logic probe_visited;
    } scan_stat_t;

endpackage

@@ rtl/dfs_ram.sv @@
module dfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/dfs_scan.sv @@
module dfs_scan import dfs_pkg::*; #(
    parameter int MAX_VERTICES = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  scan_ctrl_t                      ctrl,
    input  logic [MAX_VERTICES-1:0]         row_in,
    input  logic [$clog2(MAX_VERTICES):0]   ptr_in,
    input  logic [$clog2(MAX_VERTICES)-1:0] mark_idx,
    input  logic [$clog2(MAX_VERTICES)-1:0] probe_idx,
    input  logic [$clog2(MAX_VERTICES):0]   count,
    output scan_stat_t                      stat,
    output logic [$clog2(MAX_VERTICES):0]   ptr
);

    localparam int IW = $clog2(MAX_VERTICES);
    localparam int CW = IW + 1;

    logic [MAX_VERTICES-1:0] visited_reg;
    logic [MAX_VERTICES-1:0] row_reg;
    logic [CW-1:0]           ptr_reg;
    logic [IW-1:0]           ptr_idx;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            visited_reg <= '0;
            ptr_reg     <= '0;
        end else begin
            if (ctrl.clr_visited) begin
                visited_reg <= '0;
            end else if (ctrl.mark_visited) begin
                visited_reg[mark_idx] <= 1'b1;
            end
            if (ctrl.ptr_load) begin
                ptr_reg <= ptr_in;
            end else if (ctrl.ptr_step) begin
                ptr_reg <= ptr_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load_row) begin
            row_reg <= row_in;
        end
    end

    // one candidate neighbor per cycle while ctrl.ptr_step is set
    assign ptr_idx            = ptr_reg[IW-1:0];
    assign stat.at_end        = (ptr_reg == count);
    assign stat.hit           = !stat.at_end && row_reg[ptr_idx] && !visited_reg[ptr_idx];
    assign stat.probe_visited = visited_reg[probe_idx];
    assign ptr                = ptr_reg;

endmodule

@@ rtl/dfs_discovery_finish_times_top.sv @@
// add edge: read-modify-write of the source row, dropped if a vertex is out of range
// clear and unknown act in ST_IDLE; run: a search over the N vertices in use, paced by
//   the one-neighbor-per-cycle scan of the adjacency rows, then one result word per vertex
// throughput: one command at a time, s_ready is low until the run's last word is taken
// reset: synchronous active-low aresetn empties the graph through per-row valid bits,
//   marks all vertices unvisited and sets vertex_count to 64; no clearing pass
module dfs_discovery_finish_times_top import dfs_pkg::*; #(
    parameter int MAX_VERTICES = 64
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_word_t         s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output out_word_t        m_data
);

    localparam int IW = $clog2(MAX_VERTICES);
    localparam int CW = IW + 1;

    // control registers
    state_t                  state_reg, state_next;
    logic [CFG_W-1:0]        vcount_reg;
    logic [MAX_VERTICES-1:0] row_valid_reg, row_valid_next;
    logic [7:0]              time_reg, time_next;
    logic [CW-1:0]           depth_reg, depth_next;
    logic [CW-1:0]           root_reg, root_next;
    logic                    m_valid_reg, m_valid_next;

    // payload registers
    logic [IW-1:0]           u_reg, u_next;
    logic [IW-1:0]           emit_idx_reg, emit_idx_next;
    logic [IW-1:0]           from_reg, from_next;
    logic [IW-1:0]           to_reg, to_next;
    out_word_t               out_reg, out_next;

    // effective vertex count
    logic [CFG_W-1:0]        count7;
    logic [CW-1:0]           count;

    // memory ports
    logic [IW-1:0]           adj_raddr;
    logic [MAX_VERTICES-1:0] adj_rdata;
    logic                    adj_we;
    logic [MAX_VERTICES-1:0] adj_wdata;
    logic                    disc_we;
    logic                    fin_we;
    logic [7:0]              disc_rdata;
    logic [7:0]              fin_rdata;
    logic                    stk_we;
    logic [IW-1:0]           stk_waddr;
    logic [IW-1:0]           stk_raddr;
    logic [IW-1:0]           stk_rdata;
    logic [IW-1:0]           push_v;
    logic [CW-1:0]           depth_m2;
    logic [CW-1:0]           emit_plus1;

    // scan unit
    scan_ctrl_t              sctrl;
    scan_stat_t              sstat;
    logic [MAX_VERTICES-1:0] scan_row;
    logic [CW-1:0]           scan_ptr_in;
    logic [CW-1:0]           scan_ptr;

    logic                    s_fire;

    assign count7 = (vcount_reg > CFG_W'(MAX_VERTICES)) ? CFG_W'(MAX_VERTICES) : vcount_reg;
    assign count  = count7[CW-1:0];

    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // stack top lives in u_reg, parent entry is two below the depth
    assign depth_m2   = depth_reg - CW'(2);
    assign stk_raddr  = depth_m2[IW-1:0];
    assign stk_waddr  = depth_reg[IW-1:0];
    assign emit_plus1 = {1'b0, emit_idx_reg} + CW'(1);

    // a row never written since reset or clear reads as empty
    assign scan_row  = row_valid_reg[u_reg] ? adj_rdata : '0;
    assign adj_wdata = (row_valid_reg[from_reg] ? adj_rdata : '0)
                     | (MAX_VERTICES'(1) << to_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            vcount_reg    <= VCOUNT_RESET;
            row_valid_reg <= '0;
            time_reg      <= '0;
            depth_reg     <= '0;
            root_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            row_valid_reg <= row_valid_next;
            time_reg      <= time_next;
            depth_reg     <= depth_next;
            root_reg      <= root_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_we) begin
                vcount_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        u_reg        <= u_next;
        emit_idx_reg <= emit_idx_next;
        from_reg     <= from_next;
        to_reg       <= to_next;
        out_reg      <= out_next;
    end

    always_comb begin
        state_next     = state_reg;
        row_valid_next = row_valid_reg;
        time_next      = time_reg;
        depth_next     = depth_reg;
        root_next      = root_reg;
        m_valid_next   = m_valid_reg;
        u_next         = u_reg;
        emit_idx_next  = emit_idx_reg;
        from_next      = from_reg;
        to_next        = to_reg;
        out_next       = out_reg;
        adj_raddr      = s_data.from_vertex[IW-1:0];
        adj_we         = 1'b0;
        disc_we        = 1'b0;
        fin_we         = 1'b0;
        stk_we         = 1'b0;
        push_v         = root_reg[IW-1:0];
        sctrl          = '0;
        scan_ptr_in    = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    case (s_data.command)
                        CMD_ADD_EDGE: begin
                            from_next = s_data.from_vertex[IW-1:0];
                            to_next   = s_data.to_vertex[IW-1:0];
                            if (({1'b0, s_data.from_vertex} < count7)
                                && ({1'b0, s_data.to_vertex} < count7)) begin
                                state_next = ST_ADD_WAIT;
                            end
                        end
                        CMD_RUN: begin
                            sctrl.clr_visited = 1'b1;
                            time_next  = '0;
                            depth_next = '0;
                            root_next  = '0;
                            if (count != '0) begin
                                state_next = ST_ROOT;
                            end
                        end
                        CMD_CLEAR: begin
                            row_valid_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_ADD_WAIT: begin
                // read-modify-write of the source row
                adj_we                   = 1'b1;
                row_valid_next[from_reg] = 1'b1;
                state_next               = ST_IDLE;
            end
            ST_ROOT: begin
                if (root_reg == count) begin
                    emit_idx_next = '0;
                    state_next    = ST_EMIT_RD;
                end else if (sstat.probe_visited) begin
                    root_next = root_reg + CW'(1);
                end else begin
                    push_v = root_reg[IW-1:0];
                end
            end
            ST_LOAD: begin
                sctrl.load_row = 1'b1;
                state_next     = ST_SCAN;
            end
            ST_SCAN: begin
                if (sstat.at_end) begin
                    // finish the top vertex and pop it
                    fin_we     = 1'b1;
                    time_next  = time_reg + 8'd1;
                    depth_next = depth_reg - CW'(1);
                    if (depth_reg == CW'(1)) begin
                        state_next = ST_ROOT;
                    end else begin
                        // parent resumes just past the finished child
                        sctrl.ptr_load = 1'b1;
                        scan_ptr_in    = {1'b0, u_reg} + CW'(1);
                        state_next     = ST_POP;
                    end
                end else if (sstat.hit) begin
                    push_v = scan_ptr[IW-1:0];
                end else begin
                    sctrl.ptr_step = 1'b1;
                end
            end
            ST_POP: begin
                u_next     = stk_rdata;
                adj_raddr  = stk_rdata;
                state_next = ST_LOAD;
            end
            ST_EMIT_RD: begin
                state_next = ST_EMIT_LOAD;
            end
            ST_EMIT_LOAD: begin
                out_next.vertex        = 6'(emit_idx_reg);
                out_next.discover_time = disc_rdata;
                out_next.finish_time   = fin_rdata;
                out_next.last          = (emit_plus1 == count);
                m_valid_next           = 1'b1;
                state_next             = ST_EMIT_HOLD;
            end
            ST_EMIT_HOLD: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    if (out_reg.last) begin
                        state_next = ST_IDLE;
                    end else begin
                        emit_idx_next = emit_plus1[IW-1:0];
                        state_next    = ST_EMIT_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // discover and push, shared by a new root and a white neighbor
        if ((state_reg == ST_ROOT && root_reg != count && !sstat.probe_visited)
            || (state_reg == ST_SCAN && !sstat.at_end && sstat.hit)) begin
            sctrl.mark_visited = 1'b1;
            sctrl.ptr_load     = 1'b1;
            scan_ptr_in        = '0;
            disc_we            = 1'b1;
            stk_we             = 1'b1;
            time_next          = time_reg + 8'd1;
            depth_next         = depth_reg + CW'(1);
            u_next             = push_v;
            adj_raddr          = push_v;
            state_next         = ST_LOAD;
        end
    end

    dfs_scan #(
        .MAX_VERTICES(MAX_VERTICES)
    ) u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (sctrl),
        .row_in   (scan_row),
        .ptr_in   (scan_ptr_in),
        .mark_idx (push_v),
        .probe_idx(root_reg[IW-1:0]),
        .count    (count),
        .stat     (sstat),
        .ptr      (scan_ptr)
    );

    // adjacency rows
    dfs_ram #(
        .WIDTH(MAX_VERTICES),
        .DEPTH(MAX_VERTICES)
    ) u_adj_ram (
        .aclk (aclk),
        .we   (adj_we),
        .waddr(from_reg),
        .wdata(adj_wdata),
        .raddr(adj_raddr),
        .rdata(adj_rdata)
    );

    // discovery times
    dfs_ram #(
        .WIDTH(8),
        .DEPTH(MAX_VERTICES)
    ) u_disc_ram (
        .aclk (aclk),
        .we   (disc_we),
        .waddr(push_v),
        .wdata(time_next),
        .raddr(emit_idx_reg),
        .rdata(disc_rdata)
    );

    // finish times
    dfs_ram #(
        .WIDTH(8),
        .DEPTH(MAX_VERTICES)
    ) u_fin_ram (
        .aclk (aclk),
        .we   (fin_we),
        .waddr(u_reg),
        .wdata(time_next),
        .raddr(emit_idx_reg),
        .rdata(fin_rdata)
    );

    // path stack
    dfs_ram #(
        .WIDTH(IW),
        .DEPTH(MAX_VERTICES)
    ) u_stk_ram (
        .aclk (aclk),
        .we   (stk_we),
        .waddr(stk_waddr),
        .wdata(push_v),
        .raddr(stk_raddr),
        .rdata(stk_rdata)
    );

`ifndef SYNTHESIS
    a_mvalid_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (state_reg == ST_EMIT_HOLD))
        else $error("result word valid outside emit hold");

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("command taken while a result word is pending");

    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= CW'(MAX_VERTICES))
        else $error("path stack overflow");

    a_time_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        time_reg <= 8'(2 * MAX_VERTICES))
        else $error("timestamp beyond two per vertex");

    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_data.last) |=> s_ready)
        else $error("not ready after last result word");
`endif

endmodule
